>>> hw/rtl/ultrasonic_range_averager_macros.svh
// Assertion macros for the ultrasonic range averager.
// URA_ASSERT checks cons in the same cycle as ante; URA_ASSERT_NEXT checks it in the cycle after.
`ifndef ULTRASONIC_RANGE_AVERAGER_MACROS_SVH
`define ULTRASONIC_RANGE_AVERAGER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define URA_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ultrasonic_range_averager: same-cycle check failed");
`define URA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ultrasonic_range_averager: next-cycle check failed");
`else
`define URA_ASSERT(label, clk, rst_n, ante, cons)
`define URA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/ura_pkg.sv
`default_nettype none
package ura_pkg;

    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 24;
    localparam int unsigned TIMER_W      = 24;
    localparam int unsigned PULSE_W      = 16;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned SCALE_W      = 24;
    localparam int unsigned SCALE_HALF_W = 12;
    localparam int unsigned DIST_W       = 16;
    localparam int unsigned FRAC_SHIFT   = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_SETTLE_TICKS   = 3'd0;
    localparam t_cfg_idx CFG_PULSE_TICKS    = 3'd1;
    localparam t_cfg_idx CFG_PROBE_COUNT    = 3'd2;
    localparam t_cfg_idx CFG_DISTANCE_SCALE = 3'd3;
    localparam t_cfg_idx CFG_RANGE_LIMIT    = 3'd4;

    // Reset values of the configuration registers
    localparam logic [TIMER_W-1:0] RST_SETTLE_TICKS   = 24'd500000;
    localparam logic [PULSE_W-1:0] RST_PULSE_TICKS    = 16'd10;
    localparam logic [COUNT_W-1:0] RST_PROBE_COUNT    = 5'd5;
    localparam logic [SCALE_W-1:0] RST_DISTANCE_SCALE = 24'd9442;
    localparam logic [DIST_W-1:0]  RST_RANGE_LIMIT    = 16'd2048;

    localparam logic [DIST_W-1:0]  DIST_MAX           = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETTLE,
        ST_PULSE,
        ST_WAIT,
        ST_HIGH,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_SUM,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic clr_meas;
        logic tmr_inc;
        logic tmr_clr;
        logic width_set;
        logic width_inc;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic acc;
        logic div_start;
        logic div_step;
        logic set_last;
        logic out_load;
        logic out_trig;
        logic out_busy;
        logic out_done;
    } t_cmd;

    typedef struct packed {
        logic settle_end;
        logic pulse_end;
        logic meas_done;
        logic div_last;
    } t_sts;

endpackage
`default_nettype wire

>>> hw/rtl/ura_in_if.sv
`default_nettype none
interface ura_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink (input valid, input start_req, input echo, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ura_out_if.sv
`default_nettype none
interface ura_out_if;
    logic        valid;
    logic        ready;
    logic        trigger;
    logic        busy_res;
    logic        done_res;
    logic [15:0] distance;
    logic        out_of_range;

    modport source (
        output valid, output trigger, output busy_res, output done_res,
        output distance, output out_of_range, input ready
    );
    modport sink (
        input valid, input trigger, input busy_res, input done_res,
        input distance, input out_of_range, output ready
    );
endinterface
`default_nettype wire

>>> hw/rtl/ultrasonic_range_averager.sv
// Ultrasonic range averager: times echo pulses of an ultrasonic ranging sensor.
// Input channel i_in: one transaction per timer tick, carrying start_req and the
// sampled echo level. Output channel o_out: exactly one transaction per input
// transaction, in order, with trigger, busy_res, done_res, distance and
// out_of_range. Configuration: i_cfg_we writes i_cfg_wdata to register
// i_cfg_idx (0 settle, 1 pulse, 2 probe count, 3 scale, 4 range limit); write
// only while no measurement is running.
// The result of a tick goes into the output register in the next cycle, except for
// the tick on which the echo falls. Throughput: one tick per cycle in idle, settle,
// pulse and wait phases and while the echo stays high, as long as the output does
// not stall. The tick on which the echo falls runs three multiply steps of the
// 12-bit split scale, accumulate, check and finish, with the bit-serial divider
// between check and finish on the last probe; no tick is taken during these steps.
// Reset (synchronous, active low) returns the block to idle, clears the output flag,
// the sum and the last distance and restores the defaults; no clearing pass is needed.
// Stall: a result waits in the output register; in the tick phases the input side
// stops taking ticks while that register is full and o_out.ready is low.
`default_nettype none
`include "ultrasonic_range_averager_macros.svh"
module ultrasonic_range_averager #(
    parameter int unsigned MAX_PROBES   = 16,
    parameter int unsigned COUNTER_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    ura_in_if.sink                              i_in,
    ura_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [ura_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ura_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    ura_pkg::t_cmd w_cmd;
    ura_pkg::t_sts w_sts;

    // Controller: sequences the probe phases and the math after each probe
    ura_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_start_req (i_in.start_req),
        .i_echo      (i_in.echo),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath: timers, multiplier, accumulator, divider and the result register
    ura_dp #(
        .MAX_PROBES   (MAX_PROBES),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_trigger      (o_out.trigger),
        .o_busy_res     (o_out.busy_res),
        .o_done_res     (o_out.done_res),
        .o_distance     (o_out.distance),
        .o_out_of_range (o_out.out_of_range)
    );

    // A completed measurement never reports busy
    `URA_ASSERT(a_done_not_busy, i_clk, i_rst_n, o_out.valid && o_out.done_res, !o_out.busy_res)
    // Hold off new ticks while a result waits and the receiver stalls
    `URA_ASSERT(a_stall_blocks_input, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    // Trigger is only driven inside a running measurement
    `URA_ASSERT(a_trig_busy, i_clk, i_rst_n, o_out.valid && o_out.trigger, o_out.busy_res)
    // No tick is taken once the divider has started
    `URA_ASSERT_NEXT(a_div_blocks_input, i_clk, i_rst_n, w_cmd.div_start, !i_in.ready)

endmodule
`default_nettype wire

>>> hw/rtl/ura_ctrl.sv
`default_nettype none
module ura_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_start_req,
    input  wire logic          i_echo,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ura_pkg::t_cmd      o_cmd,
    input  wire ura_pkg::t_sts i_sts
);

    ura_pkg::t_state r_state;
    ura_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;
    logic            w_take;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ura_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_take     = 1'b0;
        case (r_state)
            ura_pkg::ST_IDLE: begin
                o_in_ready = w_out_free;
                w_take     = i_in_valid && w_out_free;
                if (w_take) begin
                    o_cmd.out_load = 1'b1;
                    if (i_start_req) begin
                        o_cmd.clr_meas = 1'b1;
                        o_cmd.out_busy = 1'b1;
                        n_state        = ura_pkg::ST_SETTLE;
                    end
                end
            end
            ura_pkg::ST_SETTLE: begin
                o_in_ready = w_out_free;
                w_take     = i_in_valid && w_out_free;
                if (w_take) begin
                    o_cmd.tmr_inc  = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_busy = 1'b1;
                    if (i_sts.settle_end) begin
                        o_cmd.tmr_clr = 1'b1;
                        n_state       = ura_pkg::ST_PULSE;
                    end
                end
            end
            ura_pkg::ST_PULSE: begin
                o_in_ready = w_out_free;
                w_take     = i_in_valid && w_out_free;
                if (w_take) begin
                    o_cmd.tmr_inc  = 1'b1;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_busy = 1'b1;
                    o_cmd.out_trig = 1'b1;
                    if (i_sts.pulse_end) begin
                        o_cmd.tmr_clr = 1'b1;
                        n_state       = ura_pkg::ST_WAIT;
                    end
                end
            end
            ura_pkg::ST_WAIT: begin
                o_in_ready = w_out_free;
                w_take     = i_in_valid && w_out_free;
                if (w_take) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_busy = 1'b1;
                    if (i_echo) begin
                        o_cmd.width_set = 1'b1;
                        n_state         = ura_pkg::ST_HIGH;
                    end
                end
            end
            ura_pkg::ST_HIGH: begin
                o_in_ready = w_out_free;
                w_take     = i_in_valid && w_out_free;
                if (w_take) begin
                    if (i_echo) begin
                        o_cmd.width_inc = 1'b1;
                        o_cmd.out_load  = 1'b1;
                        o_cmd.out_busy  = 1'b1;
                    end else begin
                        // echo fell: hold the result until the probe math is done
                        n_state = ura_pkg::ST_MUL_LO;
                    end
                end
            end
            ura_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ura_pkg::ST_MUL_HI;
            end
            ura_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ura_pkg::ST_MUL_SUM;
            end
            ura_pkg::ST_MUL_SUM: begin
                o_cmd.mul_sum = 1'b1;
                n_state       = ura_pkg::ST_ACC;
            end
            ura_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ura_pkg::ST_CHK;
            end
            ura_pkg::ST_CHK: begin
                if (i_sts.meas_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ura_pkg::ST_DIV;
                end else begin
                    n_state = ura_pkg::ST_FIN;
                end
            end
            ura_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ura_pkg::ST_FIN;
                end
            end
            ura_pkg::ST_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.tmr_clr  = 1'b1;
                    if (i_sts.meas_done) begin
                        o_cmd.set_last = 1'b1;
                        o_cmd.out_done = 1'b1;
                        n_state        = ura_pkg::ST_IDLE;
                    end else begin
                        o_cmd.out_busy = 1'b1;
                        n_state        = ura_pkg::ST_SETTLE;
                    end
                end
            end
            default: begin
                n_state = ura_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> hw/rtl/ura_dp.sv
`default_nettype none
module ura_dp #(
    parameter int unsigned MAX_PROBES   = 16,
    parameter int unsigned COUNTER_BITS = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ura_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [ura_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire ura_pkg::t_cmd                       i_cmd,
    output ura_pkg::t_sts                            o_sts,
    output logic                                     o_trigger,
    output logic                                     o_busy_res,
    output logic                                     o_done_res,
    output logic [ura_pkg::DIST_W-1:0]               o_distance,
    output logic                                     o_out_of_range
);

    localparam int unsigned CNT_W  = ura_pkg::COUNT_W;
    localparam int unsigned CAP    = (MAX_PROBES < 31) ? MAX_PROBES : 31;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);
    localparam int unsigned SUM_W  = ura_pkg::DIST_W + $clog2(CAP);
    localparam int unsigned PP_W   = COUNTER_BITS + ura_pkg::SCALE_HALF_W;
    localparam int unsigned ACC_W  = COUNTER_BITS + ura_pkg::SCALE_W;
    localparam int unsigned DQ_W   = ACC_W - ura_pkg::FRAC_SHIFT;
    localparam int unsigned DIVC_W = $clog2(SUM_W + 1);
    localparam int unsigned REM_W  = CNT_W + 1;
    localparam int unsigned TMR_W  = ura_pkg::TIMER_W;
    localparam int unsigned HALF_W = ura_pkg::SCALE_HALF_W;

    logic [TMR_W-1:0]           r_settle;
    logic [ura_pkg::PULSE_W-1:0] r_pulse;
    logic [CNT_W-1:0]           r_count;
    logic [ura_pkg::SCALE_W-1:0] r_scale;
    logic [ura_pkg::DIST_W-1:0] r_limit;

    logic [TMR_W-1:0]           r_timer;
    logic [COUNTER_BITS-1:0]    r_width;
    logic [PP_W-1:0]            r_pp;
    logic [ACC_W-1:0]           r_acc;
    logic [SUM_W-1:0]           r_sum;
    logic [CNT_W-1:0]           r_probes;
    logic                       r_range;
    logic [ura_pkg::DIST_W-1:0] r_last;
    logic [REM_W-1:0]           r_rem;
    logic [SUM_W-1:0]           r_quo;
    logic [DIVC_W-1:0]          r_divc;

    logic                       r_out_trig;
    logic                       r_out_busy;
    logic                       r_out_done;
    logic [ura_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_range;

    logic [CNT_W-1:0]           w_eff;
    logic [TMR_W-1:0]           w_timer_inc;
    logic [HALF_W-1:0]          w_mul_op;
    logic [PP_W-1:0]            w_pp;
    logic [DQ_W-1:0]            w_dq;
    logic [ura_pkg::DIST_W-1:0] w_dist;
    logic [REM_W-1:0]           w_trial;
    logic                       w_qbit;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= ura_pkg::RST_SETTLE_TICKS;
            r_pulse  <= ura_pkg::RST_PULSE_TICKS;
            r_count  <= ura_pkg::RST_PROBE_COUNT;
            r_scale  <= ura_pkg::RST_DISTANCE_SCALE;
            r_limit  <= ura_pkg::RST_RANGE_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ura_pkg::CFG_SETTLE_TICKS:   r_settle <= i_cfg_wdata;
                ura_pkg::CFG_PULSE_TICKS:    r_pulse  <= i_cfg_wdata[ura_pkg::PULSE_W-1:0];
                ura_pkg::CFG_PROBE_COUNT:    r_count  <= i_cfg_wdata[CNT_W-1:0];
                ura_pkg::CFG_DISTANCE_SCALE: r_scale  <= i_cfg_wdata;
                ura_pkg::CFG_RANGE_LIMIT:    r_limit  <= i_cfg_wdata[ura_pkg::DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the probe count into 1..cap
    always_comb begin
        if (r_count == '0) begin
            w_eff = CNT_W'(1);
        end else if (r_count > CAP_CNT) begin
            w_eff = CAP_CNT;
        end else begin
            w_eff = r_count;
        end
    end

    // Phase timer and echo width
    assign w_timer_inc = r_timer + TMR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_width <= '0;
        end else begin
            if (i_cmd.clr_meas || i_cmd.tmr_clr) begin
                r_timer <= '0;
            end else if (i_cmd.tmr_inc) begin
                r_timer <= w_timer_inc;
            end
            if (i_cmd.clr_meas) begin
                r_width <= '0;
            end else if (i_cmd.width_set) begin
                r_width <= COUNTER_BITS'(1);
            end else if (i_cmd.width_inc && (r_width != '1)) begin
                r_width <= r_width + COUNTER_BITS'(1);
            end
        end
    end

    // Width times scale, one 12-bit half of the scale per cycle
    assign w_mul_op = i_cmd.mul_hi ? r_scale[ura_pkg::SCALE_W-1:HALF_W] : r_scale[HALF_W-1:0];
    assign w_pp     = PP_W'(r_width) * PP_W'(w_mul_op);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_pp <= w_pp;
        end
        if (i_cmd.mul_hi) begin
            r_acc <= ACC_W'(r_pp);
        end else if (i_cmd.mul_sum) begin
            r_acc <= r_acc + (ACC_W'(r_pp) << HALF_W);
        end
    end

    // Drop the fraction and saturate the probe distance
    assign w_dq   = r_acc[ACC_W-1:ura_pkg::FRAC_SHIFT];
    assign w_dist = (w_dq > DQ_W'(ura_pkg::DIST_MAX)) ? ura_pkg::DIST_MAX
                                                      : w_dq[ura_pkg::DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_probes <= '0;
            r_range  <= 1'b0;
            r_last   <= '0;
            r_divc   <= '0;
        end else begin
            if (i_cmd.clr_meas) begin
                r_sum    <= '0;
                r_probes <= '0;
                r_range  <= 1'b0;
            end else if (i_cmd.acc) begin
                r_sum    <= r_sum + SUM_W'(w_dist);
                r_probes <= r_probes + CNT_W'(1);
                if (w_dist > r_limit) begin
                    r_range <= 1'b1;
                end
            end
            if (i_cmd.set_last) begin
                r_last <= r_quo[ura_pkg::DIST_W-1:0];
            end
            if (i_cmd.div_start) begin
                r_divc <= DIVC_W'(SUM_W);
            end else if (i_cmd.div_step) begin
                r_divc <= r_divc - DIVC_W'(1);
            end
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign w_trial = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};
    assign w_qbit  = (w_trial >= REM_W'(w_eff));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_sum;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? (w_trial - REM_W'(w_eff)) : w_trial;
            r_quo <= {r_quo[SUM_W-2:0], w_qbit};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_trig  <= i_cmd.out_trig;
            r_out_busy  <= i_cmd.out_busy;
            r_out_done  <= i_cmd.out_done;
            r_out_dist  <= i_cmd.set_last ? r_quo[ura_pkg::DIST_W-1:0] : r_last;
            r_out_range <= i_cmd.clr_meas ? 1'b0 : r_range;
        end
    end

    assign o_sts.settle_end = (w_timer_inc >= r_settle);
    assign o_sts.pulse_end  = (w_timer_inc >= TMR_W'(r_pulse));
    assign o_sts.meas_done  = (r_probes >= w_eff);
    assign o_sts.div_last   = (r_divc == DIVC_W'(1));

    assign o_trigger      = r_out_trig;
    assign o_busy_res     = r_out_busy;
    assign o_done_res     = r_out_done;
    assign o_distance     = r_out_dist;
    assign o_out_of_range = r_out_range;

endmodule
`default_nettype wire
